// ===== hdl/stack_bytecode_evaluator_macros.svh =====
// Assertion macros shared by the checker of the stack bytecode evaluator.
// Each macro expands to one labeled concurrent assertion on clock and reset.
`ifndef STACK_BYTECODE_EVALUATOR_MACROS_SVH
`define STACK_BYTECODE_EVALUATOR_MACROS_SVH

// Same-cycle implication.
`define SBE_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbe assertion failed");

// Next-cycle implication.
`define SBE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbe assertion failed");

`endif

// ===== hdl/sbe_pkg.sv =====
// Package of the stack bytecode evaluator: opcodes, phases, states, payload types.
// No dependencies; every module and the testbench import it.
package sbe_pkg;

   localparam int STACK_DEPTH = 20;
   localparam int STK_AW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int STK_DW      = $clog2(STACK_DEPTH + 1);
   localparam int DIV_STEPS   = 32;
   localparam int CNT_W       = $clog2(DIV_STEPS);

   typedef enum logic [7:0] {
      OP_CONST  = 8'd0,  OP_VAR  = 8'd1,  OP_NEG  = 8'd2,  OP_LNOT = 8'd3,
      OP_BNOT   = 8'd4,  OP_MUL  = 8'd5,  OP_DIV  = 8'd6,  OP_MOD  = 8'd7,
      OP_ADD    = 8'd8,  OP_SUB  = 8'd9,  OP_SHL  = 8'd10, OP_SHR  = 8'd11,
      OP_LT     = 8'd12, OP_LE   = 8'd13, OP_GT   = 8'd14, OP_GE   = 8'd15,
      OP_EQ     = 8'd16, OP_NE   = 8'd17, OP_AND  = 8'd18, OP_XOR  = 8'd19,
      OP_OR     = 8'd20, OP_STORE = 8'd21
   } opcode_type;

   typedef enum logic [2:0] {
      PH_OPCODE, PH_CONST1, PH_CONST2, PH_CONST3, PH_CONST4, PH_VARIDX, PH_ASGIDX
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_ASSIGN, ST_POP_X, ST_START, ST_WAIT, ST_FINISH, ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      CSR_INITIAL_T = 2'd0, CSR_INITIAL_A = 2'd1, CSR_INITIAL_B = 2'd2, CSR_INITIAL_C = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic signed [31:0] final_t;
      logic signed [31:0] final_a;
      logic signed [31:0] final_b;
      logic signed [31:0] final_c;
   } rsp_type;

   typedef struct packed {
      logic        start;
      opcode_type  op;
      logic [31:0] x;
      logic [31:0] y;
   } alu_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] result;
   } alu_rsp_type;

   typedef struct packed {
      logic        clear;
      logic        push;
      logic        pop;
      logic [31:0] wdata;
   } stk_cmd_type;

endpackage

// ===== hdl/sbe_alu.sv =====
// Shared arithmetic unit: registered ops plus a radix-2 iterative signed divider.
// Depends on sbe_pkg.
module sbe_alu (
   input  logic                clock,
   input  logic                reset,
   input  sbe_pkg::alu_req_type alu_req,
   output sbe_pkg::alu_rsp_type alu_rsp
);
   import sbe_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [31:0]      result_ff, result_in;
   logic [31:0]      rem_ff, rem_in;
   logic [31:0]      quot_ff, quot_in;
   logic [31:0]      dvs_ff, dvs_in;
   logic             neg_ff, neg_in;
   logic             want_rem_ff, want_rem_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [32:0] rem_sh;
   logic [32:0] diff;
   logic        ge;
   logic [31:0] rem_step, quot_step, pick;
   logic [31:0] mag_x, mag_y;
   logic [4:0]  shamt;

   assign rem_sh    = {rem_ff, quot_ff[31]};
   assign diff      = rem_sh - {1'b0, dvs_ff};
   assign ge        = ~diff[32];
   assign rem_step  = ge ? diff[31:0] : rem_sh[31:0];
   assign quot_step = {quot_ff[30:0], ge};
   assign pick      = want_rem_ff ? rem_step : quot_step;
   assign mag_x     = alu_req.x[31] ? (32'd0 - alu_req.x) : alu_req.x;
   assign mag_y     = alu_req.y[31] ? (32'd0 - alu_req.y) : alu_req.y;
   assign shamt     = alu_req.y[4:0];

   always_comb begin
      busy_in     = busy_ff;
      done_in     = 1'b0;
      result_in   = result_ff;
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      dvs_in      = dvs_ff;
      neg_in      = neg_ff;
      want_rem_in = want_rem_ff;
      count_in    = count_ff;
      if (busy_ff) begin
         rem_in   = rem_step;
         quot_in  = quot_step;
         count_in = count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_in   = 1'b0;
            done_in   = 1'b1;
            result_in = neg_ff ? (32'd0 - pick) : pick;
         end
      end else if (alu_req.start) begin
         done_in = 1'b1;
         case (alu_req.op)
            OP_NEG:  result_in = 32'd0 - alu_req.x;
            OP_LNOT: result_in = {31'd0, alu_req.x == 32'd0};
            OP_BNOT: result_in = ~alu_req.x;
            OP_MUL:  result_in = alu_req.x * alu_req.y;
            OP_DIV, OP_MOD: begin
               result_in = 32'd0;
               if (alu_req.y != 32'd0) begin
                  done_in     = 1'b0;
                  busy_in     = 1'b1;
                  rem_in      = 32'd0;
                  quot_in     = mag_x;
                  dvs_in      = mag_y;
                  want_rem_in = (alu_req.op == OP_MOD);
                  neg_in      = (alu_req.op == OP_MOD) ? alu_req.x[31]
                                                       : (alu_req.x[31] ^ alu_req.y[31]);
                  count_in    = CNT_W'(DIV_STEPS - 1);
               end
            end
            OP_ADD:  result_in = alu_req.x + alu_req.y;
            OP_SUB:  result_in = alu_req.x - alu_req.y;
            OP_SHL:  result_in = alu_req.x << shamt;
            OP_SHR:  result_in = $unsigned($signed(alu_req.x) >>> shamt);
            OP_LT:   result_in = {31'd0, $signed(alu_req.x) <  $signed(alu_req.y)};
            OP_LE:   result_in = {31'd0, $signed(alu_req.x) <= $signed(alu_req.y)};
            OP_GT:   result_in = {31'd0, $signed(alu_req.x) >  $signed(alu_req.y)};
            OP_GE:   result_in = {31'd0, $signed(alu_req.x) >= $signed(alu_req.y)};
            OP_EQ:   result_in = {31'd0, alu_req.x == alu_req.y};
            OP_NE:   result_in = {31'd0, alu_req.x != alu_req.y};
            OP_AND:  result_in = alu_req.x & alu_req.y;
            OP_XOR:  result_in = alu_req.x ^ alu_req.y;
            OP_OR:   result_in = alu_req.x | alu_req.y;
            default: result_in = 32'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff   <= result_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      dvs_ff      <= dvs_in;
      neg_ff      <= neg_in;
      want_rem_ff <= want_rem_in;
      count_ff    <= count_in;
   end

   assign alu_rsp.done   = done_ff;
   assign alu_rsp.result = result_ff;
endmodule

// ===== hdl/sbe_stack.sv =====
// Operand stack: memory with registered read, per-entry valid bits, depth counter.
// Depends on sbe_pkg.
module sbe_stack (
   input  logic                clock,
   input  logic                reset,
   input  sbe_pkg::stk_cmd_type stk_cmd,
   output logic [31:0]         rd_data
);
   import sbe_pkg::*;

   logic [31:0]            mem_ff [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] valid_ff;
   logic [STK_DW-1:0]      depth_ff, depth_in;
   logic [31:0]            rd_data_ff;
   logic [STK_DW-1:0]      below;
   logic [STK_AW-1:0]      rd_addr, wr_addr;
   logic                   full, do_write;

   // An empty stack pops entry 0 and stays empty.
   assign below    = (depth_ff == '0) ? '0 : (depth_ff - 1'b1);
   assign rd_addr  = below[STK_AW-1:0];
   assign wr_addr  = depth_ff[STK_AW-1:0];
   assign full     = (depth_ff == STK_DW'(STACK_DEPTH));
   assign do_write = stk_cmd.push && !full;

   always_comb begin
      depth_in = depth_ff;
      if (stk_cmd.clear) begin
         depth_in = '0;
      end else if (stk_cmd.pop) begin
         depth_in = below;
      end else if (do_write) begin
         depth_in = depth_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
         valid_ff <= '0;
      end else begin
         depth_ff <= depth_in;
         if (do_write) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem_ff[wr_addr] <= stk_cmd.wdata;
      end
      if (stk_cmd.pop) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : 32'd0;
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== hdl/stack_bytecode_evaluator.sv =====
// Stack bytecode evaluator, top level: byte sequencer, variables, config registers.
// Depends on sbe_pkg, sbe_alu and sbe_stack.
// Sequencing: a request is taken only in the idle state, once the previous byte has passed decode and
// finish; an assignment index also passes assign, unary opcodes pass start and wait, binary opcodes
// also pop x first, and divide or modulo by a nonzero value waits out its 32 divider steps. On the last
// byte the response is registered in the emit state, which waits while an older response stalls.
// Reset (synchronous) clears the config registers, stack and variables to zero.
module stack_bytecode_evaluator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sbe_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sbe_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [31:0]      csr_data
);
   import sbe_pkg::*;

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic        inside_ff, inside_in;
   logic [23:0] gather_ff, gather_in;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic [31:0] y_ff, y_in;
   logic [31:0] init_ff [4];
   logic [31:0] var_ff [4];
   logic [31:0] var_in [4];
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   alu_req_type alu_req;
   alu_rsp_type alu_rsp;
   stk_cmd_type stk_cmd;
   logic [31:0] rd_data;

   logic accept, rsp_free, is_unary, is_binary;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign is_unary  = byte_ff inside {OP_NEG, OP_LNOT, OP_BNOT};
   assign is_binary = byte_ff inside {[OP_MUL:OP_OR]};

   sbe_alu u_alu (.clock(clock), .reset(reset), .alu_req(alu_req), .alu_rsp(alu_rsp));
   sbe_stack u_stack (.clock(clock), .reset(reset), .stk_cmd(stk_cmd), .rd_data(rd_data));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_DECODE;
         ST_DECODE: begin
            state_in = ST_FINISH;
            if (phase_ff == PH_ASGIDX) begin
               state_in = ST_ASSIGN;
            end else if (phase_ff == PH_OPCODE && is_unary) begin
               state_in = ST_START;
            end else if (phase_ff == PH_OPCODE && is_binary) begin
               state_in = ST_POP_X;
            end
         end
         ST_ASSIGN: state_in = ST_FINISH;
         ST_POP_X:  state_in = ST_START;
         ST_START:  state_in = ST_WAIT;
         ST_WAIT:   if (alu_rsp.done) state_in = ST_FINISH;
         ST_FINISH: state_in = last_ff ? ST_EMIT : ST_IDLE;
         ST_EMIT:   if (rsp_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      phase_in      = phase_ff;
      inside_in     = inside_ff;
      gather_in     = gather_ff;
      y_in          = y_ff;
      var_in        = var_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      stk_cmd       = '0;
      alu_req.start = 1'b0;
      alu_req.op    = opcode_type'(byte_ff);
      alu_req.x     = rd_data;
      alu_req.y     = y_ff;
      case (state_ff)
         ST_IDLE: begin
            // The first request of a program reloads the variables and empties the stack.
            if (accept && !inside_ff) begin
               var_in        = init_ff;
               stk_cmd.clear = 1'b1;
               phase_in      = PH_OPCODE;
               gather_in     = 24'd0;
               inside_in     = 1'b1;
            end
         end
         ST_DECODE: begin
            phase_in = PH_OPCODE;
            case (phase_ff)
               PH_CONST1: begin
                  gather_in = {16'd0, byte_ff};
                  phase_in  = PH_CONST2;
               end
               PH_CONST2: begin
                  gather_in[15:8] = byte_ff;
                  phase_in        = PH_CONST3;
               end
               PH_CONST3: begin
                  gather_in[23:16] = byte_ff;
                  phase_in         = PH_CONST4;
               end
               PH_CONST4: begin
                  stk_cmd.push  = 1'b1;
                  stk_cmd.wdata = {byte_ff, gather_ff};
               end
               PH_VARIDX: begin
                  stk_cmd.push  = 1'b1;
                  stk_cmd.wdata = var_ff[byte_ff[1:0]];
               end
               PH_ASGIDX: stk_cmd.pop = 1'b1;
               default: begin
                  if (byte_ff == OP_CONST) begin
                     phase_in  = PH_CONST1;
                     gather_in = 24'd0;
                  end else if (byte_ff == OP_VAR) begin
                     phase_in = PH_VARIDX;
                  end else if (byte_ff == OP_STORE) begin
                     phase_in = PH_ASGIDX;
                  end else if (is_unary || is_binary) begin
                     stk_cmd.pop = 1'b1;
                  end
               end
            endcase
         end
         ST_ASSIGN: var_in[byte_ff[1:0]] = rd_data;
         ST_POP_X: begin
            y_in        = rd_data;
            stk_cmd.pop = 1'b1;
         end
         ST_START: alu_req.start = 1'b1;
         ST_WAIT: begin
            if (alu_rsp.done) begin
               stk_cmd.push  = 1'b1;
               stk_cmd.wdata = alu_rsp.result;
            end
         end
         ST_FINISH: if (last_ff) stk_cmd.pop = 1'b1;
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.result_value = rd_data;
               rsp_in.final_t      = var_ff[0];
               rsp_in.final_a      = var_ff[1];
               rsp_in.final_b      = var_ff[2];
               rsp_in.final_c      = var_ff[3];
               phase_in            = PH_OPCODE;
               gather_in           = 24'd0;
               inside_in           = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_OPCODE;
         inside_ff    <= 1'b0;
         gather_ff    <= 24'd0;
         rsp_valid_ff <= 1'b0;
         var_ff       <= '{default: 32'd0};
         init_ff      <= '{default: 32'd0};
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         inside_ff    <= inside_in;
         gather_ff    <= gather_in;
         rsp_valid_ff <= rsp_valid_in;
         var_ff       <= var_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_INITIAL_T: init_ff[0] <= csr_data;
               CSR_INITIAL_A: init_ff[1] <= csr_data;
               CSR_INITIAL_B: init_ff[2] <= csr_data;
               CSR_INITIAL_C: init_ff[3] <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      y_ff   <= y_in;
      rsp_ff <= rsp_in;
      if (accept) begin
         byte_ff <= req_data.code_byte;
         last_ff <= req_data.last_byte;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

// ===== hdl/sbe_checker.sv =====
// Port-level checker for the stack bytecode evaluator, bound to the top level.
// Depends on sbe_pkg and stack_bytecode_evaluator_macros.svh.
`include "stack_bytecode_evaluator_macros.svh"

module sbe_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sbe_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sbe_pkg::rsp_type rsp_data
);
   import sbe_pkg::*;

   // A stalled response keeps its valid and its payload.
   `SBE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `SBE_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data))
   // After each accepted request the block is not ready in the next cycle.
   `SBE_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
   // Only the last byte of a program can raise a response.
   `SBE_ASSERT_NEXT(a_no_early_rsp, req_valid && req_ready && !req_data.last_byte,
                    !$rose(rsp_valid))
endmodule

bind stack_bytecode_evaluator sbe_checker u_sbe_checker (.*);

// ===== tb/sv/tb_stack_bytecode_evaluator.sv =====
// Self-checking testbench of the stack bytecode evaluator: random and directed programs.
// Depends on sbe_pkg and stack_bytecode_evaluator; predicts each program result in line.
module tb_stack_bytecode_evaluator;
   timeunit 1ns;
   timeprecision 1ps;
   import sbe_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   stack_bytecode_evaluator DUT (.*);

   always #5 clock = ~clock;

   // Predictor state.
   logic [31:0] initial_vars [4];
   logic [31:0] op_stack [STACK_DEPTH];
   int unsigned depth;
   logic [31:0] vars [4];
   phase_type phase;
   logic [31:0] gather;
   bit in_program;

   req_type pending_bytes [$];
   rsp_type expected_results [$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_rsp = 0;
   longint cycles = 0;

   task automatic report(input string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   function automatic void push_word(input logic [31:0] v);
      if (depth < STACK_DEPTH) begin
         op_stack[depth] = v;
         depth++;
      end
   endfunction

   function automatic logic [31:0] pop_word();
      if (depth > 0) depth--;
      return op_stack[depth];
   endfunction

   function automatic logic [31:0] signed_divide(input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input bit remainder);
      logic [31:0] mx, my, r;
      if (y == 0) return 32'd0;
      mx = x[31] ? -x : x;
      my = y[31] ? -y : y;
      if (remainder) begin
         r = mx % my;
         return x[31] ? -r : r;
      end
      r = mx / my;
      return (x[31] ^ y[31]) ? -r : r;
   endfunction

   function automatic logic [31:0] binary_result(input opcode_type op,
                                                 input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
      case (op)
         OP_MUL: return x * y;
         OP_DIV: return signed_divide(x, y, 1'b0);
         OP_MOD: return signed_divide(x, y, 1'b1);
         OP_ADD: return x + y;
         OP_SUB: return x - y;
         OP_SHL: return x << y[4:0];
         OP_SHR: return x >>> y[4:0];
         OP_LT: return {31'd0, x < y};
         OP_LE: return {31'd0, x <= y};
         OP_GT: return {31'd0, x > y};
         OP_GE: return {31'd0, x >= y};
         OP_EQ: return {31'd0, x == y};
         OP_NE: return {31'd0, x != y};
         OP_AND: return x & y;
         OP_XOR: return x ^ y;
         default: return x | y;
      endcase
   endfunction

   function automatic void predict_byte(input req_type r);
      logic [7:0] b;
      logic [31:0] x, y;
      rsp_type res;
      b = r.code_byte;
      if (!in_program) begin
         vars = initial_vars;
         depth = 0;
         phase = PH_OPCODE;
         gather = 0;
         in_program = 1'b1;
      end
      case (phase)
         PH_CONST1: begin gather = {24'd0, b}; phase = PH_CONST2; end
         PH_CONST2: begin gather[15:8] = b; phase = PH_CONST3; end
         PH_CONST3: begin gather[23:16] = b; phase = PH_CONST4; end
         PH_CONST4: begin push_word({b, gather[23:0]}); phase = PH_OPCODE; end
         PH_VARIDX: begin push_word(vars[b[1:0]]); phase = PH_OPCODE; end
         PH_ASGIDX: begin vars[b[1:0]] = pop_word(); phase = PH_OPCODE; end
         default: begin
            phase = PH_OPCODE;
            if (b == OP_CONST) begin
               phase = PH_CONST1;
               gather = 0;
            end else if (b == OP_VAR) phase = PH_VARIDX;
            else if (b == OP_STORE) phase = PH_ASGIDX;
            else if (b == OP_NEG) push_word(-pop_word());
            else if (b == OP_LNOT) push_word({31'd0, pop_word() == 0});
            else if (b == OP_BNOT) push_word(~pop_word());
            else if (b >= OP_MUL && b <= OP_OR) begin
               y = pop_word();
               x = pop_word();
               push_word(binary_result(opcode_type'(b), x, y));
            end
         end
      endcase
      if (r.last_byte) begin
         res.result_value = pop_word();
         res.final_t = vars[0];
         res.final_a = vars[1];
         res.final_b = vars[2];
         res.final_c = vars[3];
         expected_results.push_back(res);
         phase = PH_OPCODE;
         gather = 0;
         in_program = 1'b0;
      end
   endfunction

   // Driver: sends queued bytes; a new byte may follow an accepted one in the same step.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) predict_byte(req_data);
         if (pending_bytes.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_data <= pending_bytes.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: compares each result with the oldest expectation.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report("result with no expectation");
            end else begin
               rsp_type e;
               e = expected_results.pop_front();
               if (rsp_data.result_value !== e.result_value)
                  report($sformatf("result %h exp %h", rsp_data.result_value, e.result_value));
               if (rsp_data.final_t !== e.final_t) report("final_t");
               if (rsp_data.final_a !== e.final_a) report("final_a");
               if (rsp_data.final_b !== e.final_b) report("final_b");
               if (rsp_data.final_c !== e.final_c) report("final_c");
            end
         end
         rsp_ready <= (hold_rsp == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Long receiver hold-off, counted in its own process.
   initial begin
      int n;
      wait (hold_rsp == 1);
      for (n = 0; n < 400; n++) @(posedge clock);
      hold_rsp = 0;
   end

   task automatic add_byte(input logic [7:0] b, input bit last);
      req_type r;
      r.code_byte = b;
      r.last_byte = last;
      pending_bytes.push_back(r);
   endtask

   task automatic add_const(input logic [31:0] v);
      add_byte(OP_CONST, 1'b0);
      add_byte(v[7:0], 1'b0);
      add_byte(v[15:8], 1'b0);
      add_byte(v[23:16], 1'b0);
      add_byte(v[31:24], 1'b0);
   endtask

   task automatic wait_drained();
      int n;
      while (pending_bytes.size() > 0 || req_valid || expected_results.size() > 0)
         @(posedge clock);
      // Extra idle cycles let the block settle back to its idle state.
      for (n = 0; n < 60; n++) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] v);
      csr_index <= idx;
      csr_data <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      initial_vars[idx] = v;
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(5, 0))
         0: return 32'h8000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h7FFF_FFFF;
         3: return $urandom_range(40, 0);
         default: return $urandom;
      endcase
   endfunction

   // A random program: mostly well-formed, sometimes truncated or junk.
   task automatic add_program();
      int len, k, r;
      len = $urandom_range(12, 1);
      for (k = 0; k < len; k++) begin
         r = $urandom_range(99, 0);
         if (r < 30) add_const(random_word());
         else if (r < 45) begin
            add_byte(OP_VAR, 1'b0);
            add_byte(8'($urandom_range(255, 0)), 1'b0);
         end else if (r < 52) begin
            add_byte(OP_STORE, 1'b0);
            add_byte(8'($urandom_range(255, 0)), 1'b0);
         end else if (r < 95) add_byte(8'($urandom_range(OP_OR, OP_NEG)), 1'b0);
         else add_byte(8'($urandom_range(255, 0)), 1'b0);
      end
      add_byte(8'($urandom_range(255, 0)), 1'b1);
   endtask

   initial begin
      int k, ph;
      initial_vars = '{default: 0};
      op_stack = '{default: 0};
      vars = '{default: 0};
      depth = 0;
      phase = PH_OPCODE;
      gather = 0;
      in_program = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: pop from an empty stack before any write, then extremes.
      add_byte(OP_NEG, 1'b1);
      wait_drained();
      write_reg(CSR_INITIAL_T, 32'h8000_0000);
      write_reg(CSR_INITIAL_A, 32'h7FFF_FFFF);
      write_reg(CSR_INITIAL_B, 32'hFFFF_FFFF);
      write_reg(CSR_INITIAL_C, 32'h0000_0000);
      add_const(32'h8000_0000); add_const(32'hFFFF_FFFF); add_byte(OP_DIV, 1'b1);
      add_const(32'h8000_0000); add_const(32'hFFFF_FFFF); add_byte(OP_MOD, 1'b1);
      add_byte(OP_VAR, 1'b0); add_byte(8'hFD, 1'b0); add_const(0); add_byte(OP_DIV, 1'b1);
      add_byte(OP_VAR, 1'b0); add_byte(8'h00, 1'b0); add_const(33); add_byte(OP_SHR, 1'b1);
      add_byte(OP_VAR, 1'b0); add_byte(8'h01, 1'b0); add_byte(OP_STORE, 1'b0);
      add_byte(8'hFE, 1'b0); add_byte(8'hFF, 1'b1);
      add_byte(OP_CONST, 1'b0); add_byte(8'h12, 1'b1);
      add_byte(OP_STORE, 1'b1);
      for (k = 0; k < STACK_DEPTH + 2; k++) begin
         add_byte(OP_VAR, 1'b0);
         add_byte({6'd0, k[1:0]}, 1'b0);
      end
      add_byte(OP_ADD, 1'b1);
      wait_drained();

      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 57; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 57; end
            3: begin send_idle_pct = 8; recv_stall_pct = 8; hold_rsp = 1; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         write_reg(csr_index_type'($urandom_range(3, 0)), random_word());
         write_reg(csr_index_type'($urandom_range(3, 0)), random_word());
         for (k = 0; k < 24; k++) add_program();
         wait_drained();
      end

      for (k = 0; k < 40; k++) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
